### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising edge outside of reset.
`define TCB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be true at a rising edge outside of reset.
`define TCB_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define TCB_ASSERT(label, clk, rst, prop, msg)
`define TCB_NEVER(label, clk, rst, cond, msg)

`endif

`endif

### rtl/tcb_pkg.sv
// ----------------------------------------------------------------------------
// tcb_pkg
// Types and constants of the text console cell buffer.
// ----------------------------------------------------------------------------
package tcb_pkg;

   localparam int MAX_COLUMNS = 64;
   localparam int MAX_LINES   = 32;
   localparam int COL_BITS    = $clog2(MAX_COLUMNS);
   localparam int LINE_BITS   = $clog2(MAX_LINES);
   localparam int ADDR_BITS   = COL_BITS + LINE_BITS;
   localparam int DEPTH       = MAX_LINES * MAX_COLUMNS;
   localparam int CHAR_BITS   = 8;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 7;
   localparam int COLS_REG_BITS  = 7;
   localparam int LINES_REG_BITS = 6;

   localparam logic [COLS_REG_BITS-1:0]  COLS_RESET  = 7'd30;
   localparam logic [LINES_REG_BITS-1:0] LINES_RESET = 6'd22;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLUMNS = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINES   = 1'b1;

   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [CHAR_BITS-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'h20;

   typedef struct packed {
      logic                 cmd;
      logic [7:0]           char_in;
      logic [4:0]           read_line;
      logic [5:0]           read_column;
   } req_type;

   typedef struct packed {
      logic [4:0]           cell_line;
      logic [5:0]           cell_column;
      logic [7:0]           cell_char;
      logic [1:0]           scroll_count;
   } rsp_type;

endpackage

### rtl/text_console_cell_buffer_top.sv
// ----------------------------------------------------------------------------
// text_console_cell_buffer_top
// Character cell store of a scrolling text console with put and read requests.
// ----------------------------------------------------------------------------
// After reset the store is cleared to spaces, one cell a cycle, through all
// 2048 cells; no request is taken in that time, configuration writes are.
// A read request passes the memory read, then the response register.
// A put request without scrolling is registered, then written to the cell
// memory as the response register is loaded. Each scroll is one copy pass
// through the single-port-pair cell memory: w*(h-1) cells moved, the drain
// of the last copy write, then w cells blanked, with w columns and h lines
// in use. A new request is taken while the last response waits.
module text_console_cell_buffer_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tcb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tcb_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [tcb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tcb_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import tcb_pkg::*;

`include "assert_macros.svh"

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_SCROLL, ST_FILL, ST_WRITE, ST_READ
   } state_type;

   state_type state_ff;

   logic [COLS_REG_BITS-1:0]  cfg_cols_ff;
   logic [LINES_REG_BITS-1:0] cfg_lines_ff;

   logic [LINE_BITS-1:0] cursor_line_ff;
   logic [COL_BITS:0]    cursor_column_ff;

   logic [ADDR_BITS-1:0] clear_addr_ff;
   logic [LINE_BITS-1:0] cnt_line_ff;
   logic [COL_BITS-1:0]  cnt_col_ff;
   logic [1:0]           scrolls_left_ff;
   logic                 pend_ff;
   logic [ADDR_BITS-1:0] pend_addr_ff;

   logic [LINE_BITS-1:0] put_line_ff;
   logic [COL_BITS-1:0]  put_col_ff;
   logic [CHAR_BITS-1:0] put_char_ff;
   logic [1:0]           put_scrolls_ff;

   logic [LINE_BITS-1:0] rd_line_ff;
   logic [COL_BITS-1:0]  rd_col_ff;
   logic                 rd_in_store_ff;

   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic [CHAR_BITS-1:0] cell_mem [DEPTH];
   logic [CHAR_BITS-1:0] rd_data_ff;

   logic                 mem_we;
   logic [ADDR_BITS-1:0] mem_waddr;
   logic [CHAR_BITS-1:0] mem_wdata;
   logic                 mem_re;
   logic [ADDR_BITS-1:0] mem_raddr;

   logic [COL_BITS:0]    eff_w;
   logic [LINE_BITS:0]   eff_h;
   logic [LINE_BITS+1:0] calc_line;
   logic [LINE_BITS+1:0] calc_excess;
   logic [COL_BITS:0]    calc_col;
   logic [1:0]           calc_scrolls;

   logic                 req_fire;
   logic                 slot_free;
   logic                 rsp_load;
   logic                 last_col;
   logic                 last_copy_line;
   logic                 read_in_store;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = slot_free && (state_ff == ST_WRITE || state_ff == ST_READ);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Register values out of range are clamped into 1..MAX.
   always_comb begin
      if (cfg_cols_ff == '0) begin
         eff_w = (COL_BITS+1)'(1);
      end else if (cfg_cols_ff > COLS_REG_BITS'(MAX_COLUMNS)) begin
         eff_w = (COL_BITS+1)'(MAX_COLUMNS);
      end else begin
         eff_w = cfg_cols_ff[COL_BITS:0];
      end
      if (cfg_lines_ff == '0) begin
         eff_h = (LINE_BITS+1)'(1);
      end else if (cfg_lines_ff > LINES_REG_BITS'(MAX_LINES)) begin
         eff_h = (LINE_BITS+1)'(MAX_LINES);
      end else begin
         eff_h = cfg_lines_ff[LINE_BITS:0];
      end
   end

   // Cursor movement of a put: wrap, then newline, then clamp to the last line.
   always_comb begin
      calc_line = {2'b00, cursor_line_ff};
      calc_col  = cursor_column_ff;
      if (calc_col >= eff_w) begin
         calc_line = calc_line + (LINE_BITS+2)'(1);
         calc_col  = '0;
      end
      if (req_data.char_in == CH_NEWLINE) begin
         calc_line = calc_line + (LINE_BITS+2)'(1);
         calc_col  = '0;
      end
      calc_excess  = calc_line - ({1'b0, eff_h} - (LINE_BITS+2)'(1));
      calc_scrolls = 2'd0;
      if (calc_line >= {1'b0, eff_h}) begin
         calc_scrolls = (calc_excess > (LINE_BITS+2)'(2)) ? 2'd2 : calc_excess[1:0];
         calc_line    = {1'b0, eff_h} - (LINE_BITS+2)'(1);
      end
   end

   assign last_col       = ({1'b0, cnt_col_ff} == eff_w - (COL_BITS+1)'(1));
   assign last_copy_line = ({1'b0, cnt_line_ff} == eff_h - (LINE_BITS+1)'(2));
   assign read_in_store  = (32'(req_data.read_line) < MAX_LINES) &&
                           (32'(req_data.read_column) < MAX_COLUMNS);

   // Memory read port: read requests and the source side of a scroll copy.
   always_comb begin
      mem_re    = 1'b0;
      mem_raddr = {cnt_line_ff + LINE_BITS'(1), cnt_col_ff};
      if (state_ff == ST_SCROLL) begin
         mem_re = 1'b1;
      end else if (req_fire && req_data.cmd == CMD_READ) begin
         mem_re    = 1'b1;
         mem_raddr = {req_data.read_line[LINE_BITS-1:0],
                      req_data.read_column[COL_BITS-1:0]};
      end
   end

   // Memory write port. A pending copy write wins over the blanking of the
   // bottom line, which then waits.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = pend_addr_ff;
      mem_wdata = rd_data_ff;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clear_addr_ff;
         mem_wdata = CH_SPACE;
      end else if (pend_ff) begin
         mem_we = 1'b1;
      end else if (state_ff == ST_FILL) begin
         mem_we    = 1'b1;
         mem_waddr = {eff_h[LINE_BITS-1:0] - LINE_BITS'(1), cnt_col_ff};
         mem_wdata = CH_SPACE;
      end else if (state_ff == ST_WRITE && slot_free) begin
         mem_we    = 1'b1;
         mem_waddr = {put_line_ff, put_col_ff};
         mem_wdata = put_char_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= cell_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_cols_ff  <= COLS_RESET;
         cfg_lines_ff <= LINES_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COLUMNS: cfg_cols_ff  <= csr_data[COLS_REG_BITS-1:0];
            CSR_LINES:   cfg_lines_ff <= csr_data[LINES_REG_BITS-1:0];
            default:     cfg_cols_ff  <= cfg_cols_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clear_addr_ff    <= '0;
         pend_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         cursor_line_ff   <= '0;
         cursor_column_ff <= '0;
         scrolls_left_ff  <= '0;
      end else begin
         // The cell read in a copy cycle lands one line up in the next cycle.
         pend_ff <= (state_ff == ST_SCROLL);
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clear_addr_ff <= clear_addr_ff + ADDR_BITS'(1);
               if (clear_addr_ff == ADDR_BITS'(DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  if (req_data.cmd == CMD_READ) begin
                     rd_line_ff     <= req_data.read_line[LINE_BITS-1:0];
                     rd_col_ff      <= req_data.read_column[COL_BITS-1:0];
                     rd_in_store_ff <= read_in_store;
                     state_ff       <= ST_READ;
                  end else begin
                     put_line_ff     <= calc_line[LINE_BITS-1:0];
                     put_col_ff      <= calc_col[COL_BITS-1:0];
                     put_char_ff     <= req_data.char_in;
                     put_scrolls_ff  <= calc_scrolls;
                     scrolls_left_ff <= calc_scrolls;
                     cnt_line_ff     <= '0;
                     cnt_col_ff      <= '0;
                     if (calc_scrolls == 2'd0) begin
                        state_ff <= ST_WRITE;
                     end else if (eff_h > (LINE_BITS+1)'(1)) begin
                        state_ff <= ST_SCROLL;
                     end else begin
                        state_ff <= ST_FILL;
                     end
                  end
               end
            end
            ST_SCROLL: begin
               pend_addr_ff <= {cnt_line_ff, cnt_col_ff};
               if (last_col) begin
                  cnt_col_ff <= '0;
                  if (last_copy_line) begin
                     state_ff <= ST_FILL;
                  end else begin
                     cnt_line_ff <= cnt_line_ff + LINE_BITS'(1);
                  end
               end else begin
                  cnt_col_ff <= cnt_col_ff + COL_BITS'(1);
               end
            end
            ST_FILL: begin
               if (!pend_ff) begin
                  if (last_col) begin
                     cnt_col_ff      <= '0;
                     cnt_line_ff     <= '0;
                     scrolls_left_ff <= scrolls_left_ff - 2'd1;
                     if (scrolls_left_ff == 2'd1) begin
                        state_ff <= ST_WRITE;
                     end else if (eff_h > (LINE_BITS+1)'(1)) begin
                        state_ff <= ST_SCROLL;
                     end
                  end else begin
                     cnt_col_ff <= cnt_col_ff + COL_BITS'(1);
                  end
               end
            end
            ST_WRITE: begin
               if (slot_free) begin
                  rsp_data_ff.cell_line     <= put_line_ff;
                  rsp_data_ff.cell_column   <= put_col_ff;
                  rsp_data_ff.cell_char     <= put_char_ff;
                  rsp_data_ff.scroll_count  <= put_scrolls_ff;
                  cursor_line_ff            <= put_line_ff;
                  cursor_column_ff          <= {1'b0, put_col_ff} + (COL_BITS+1)'(1);
                  state_ff                  <= ST_IDLE;
               end
            end
            ST_READ: begin
               if (slot_free) begin
                  rsp_data_ff.cell_line    <= rd_line_ff;
                  rsp_data_ff.cell_column  <= rd_col_ff;
                  rsp_data_ff.cell_char    <= rd_in_store_ff ? rd_data_ff : CH_SPACE;
                  rsp_data_ff.scroll_count <= 2'd0;
                  state_ff                 <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `TCB_ASSERT(a_accept_leaves_idle, clock, reset, req_fire |=> state_ff != ST_IDLE, "request accepted but block stayed idle")
   `TCB_NEVER(a_copy_vs_put, clock, reset, pend_ff && state_ff == ST_WRITE, "scroll copy write overlaps the character write")
   `TCB_ASSERT(a_scroll_pending, clock, reset, (state_ff == ST_SCROLL || state_ff == ST_FILL) |-> scrolls_left_ff != 2'd0, "scroll pass without a scroll left")
   `TCB_ASSERT(a_put_line_in_area, clock, reset, state_ff == ST_WRITE |-> {1'b0, put_line_ff} < eff_h, "character write below the last line in use")
   `TCB_NEVER(a_no_request_in_clear, clock, reset, state_ff == ST_CLEAR && $past(state_ff) != ST_CLEAR, "clearing pass restarted outside reset")

endmodule
